FILE: src/qvr_pkg.sv
package qvr_pkg;

  typedef struct packed {
    logic load_a;
    logic load_b;
  } pair_ctl_t;

  typedef struct packed {
    logic a;
    logic b;
  } pair_vld_t;

endpackage

FILE: src/quaternion_vector_rotate.sv
// Rotates a vector by a Q1.15 quaternion as q*(v,0)*conj(q), one transaction per cycle unless stalled.
// Each of the two quaternion products takes one stage of registered multipliers and
// one stage of add, round and (for the second) saturate.
// A stall on the result side holds only the stages that are full, so empty stages
// keep filling; vec_stall rises only when every stage holds a transaction.
// No normalisation is applied, and clipped flags any saturated component.
module quaternion_vector_rotate #(
  parameter int COMP_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         vec_valid,
  output logic                         vec_stall,
  input  logic signed [COMP_WIDTH-1:0] quat_x,
  input  logic signed [COMP_WIDTH-1:0] quat_y,
  input  logic signed [COMP_WIDTH-1:0] quat_z,
  input  logic signed [COMP_WIDTH-1:0] quat_w,
  input  logic signed [COMP_WIDTH-1:0] vec_x,
  input  logic signed [COMP_WIDTH-1:0] vec_y,
  input  logic signed [COMP_WIDTH-1:0] vec_z,
  output logic                         rot_valid,
  input  logic                         rot_stall,
  output logic signed [COMP_WIDTH-1:0] rot_x,
  output logic signed [COMP_WIDTH-1:0] rot_y,
  output logic signed [COMP_WIDTH-1:0] rot_z,
  output logic                         clipped
);
  import qvr_pkg::*;

  pair_ctl_t                    ctl_conj;
  pair_ctl_t                    ctl_rot;
  pair_vld_t                    vld_conj;
  pair_vld_t                    vld_rot;
  logic signed [COMP_WIDTH-1:0] quat_in [4];
  logic signed [COMP_WIDTH-1:0] vec_in [3];
  logic signed [COMP_WIDTH-1:0] quat_mid [4];
  logic signed [COMP_WIDTH+3:0] t_vec [3];
  logic signed [COMP_WIDTH+3:0] t_w;
  logic signed [COMP_WIDTH-1:0] rot [3];

  assign quat_in = '{quat_x, quat_y, quat_z, quat_w};
  assign vec_in  = '{vec_x, vec_y, vec_z};

  // advance a stage when it is empty or the next one advances
  assign ctl_rot.load_b  = !vld_rot.b || !rot_stall;
  assign ctl_rot.load_a  = !vld_rot.a || ctl_rot.load_b;
  assign ctl_conj.load_b = !vld_conj.b || ctl_rot.load_a;
  assign ctl_conj.load_a = !vld_conj.a || ctl_conj.load_b;
  assign vec_stall       = !ctl_conj.load_a;

  qvr_conj_mul #(
    .COMP_WIDTH(COMP_WIDTH)
  ) u_conj (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vec_valid),
    .ctl      (ctl_conj),
    .quat     (quat_in),
    .vec      (vec_in),
    .vld      (vld_conj),
    .t_vec    (t_vec),
    .t_w      (t_w),
    .quat_d   (quat_mid)
  );

  qvr_rot_mul #(
    .COMP_WIDTH(COMP_WIDTH)
  ) u_rot (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld_conj.b),
    .ctl      (ctl_rot),
    .quat     (quat_mid),
    .t_vec    (t_vec),
    .t_w      (t_w),
    .vld      (vld_rot),
    .rot      (rot),
    .clipped  (clipped)
  );

  assign rot_valid = vld_rot.b;
  assign rot_x     = rot[0];
  assign rot_y     = rot[1];
  assign rot_z     = rot[2];

endmodule

FILE: src/qvr_conj_mul.sv
module qvr_conj_mul #(
  parameter int COMP_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  qvr_pkg::pair_ctl_t              ctl,
  input  logic signed [COMP_WIDTH-1:0]    quat [4],
  input  logic signed [COMP_WIDTH-1:0]    vec [3],
  output qvr_pkg::pair_vld_t              vld,
  output logic signed [COMP_WIDTH+3:0]    t_vec [3],
  output logic signed [COMP_WIDTH+3:0]    t_w,
  output logic signed [COMP_WIDTH-1:0]    quat_d [4]
);
  import qvr_pkg::*;

  localparam int F  = COMP_WIDTH - 1;
  localparam int PW = 2 * COMP_WIDTH;
  localparam int SW = 2 * COMP_WIDTH + 2;
  localparam int TW = COMP_WIDTH + 4;
  localparam logic signed [SW-1:0] Half = SW'(64'd1 << (F - 1));

  logic signed [PW-1:0]         prod_main [3];
  logic signed [PW-1:0]         prod_pos [3];
  logic signed [PW-1:0]         prod_neg [3];
  logic signed [PW-1:0]         prod_dot [3];
  logic signed [COMP_WIDTH-1:0] quat_a [4];
  logic signed [SW-1:0]         sum_vec [3];
  logic signed [SW-1:0]         sum_dot;
  logic signed [SW-1:0]         shift_vec [3];
  logic signed [SW-1:0]         shift_dot;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld.a <= 1'b0;
      vld.b <= 1'b0;
    end else begin
      if (ctl.load_a) begin
        vld.a <= in_valid;
      end
      if (ctl.load_b) begin
        vld.b <= vld.a;
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_comp
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    always_ff @(posedge clk) begin
      if (ctl.load_a) begin
        prod_main[i] <= quat[3] * vec[i];
        prod_pos[i]  <= quat[J] * vec[K];
        prod_neg[i]  <= quat[K] * vec[J];
        prod_dot[i]  <= quat[i] * vec[i];
      end
    end

    always_comb begin
      sum_vec[i]   = SW'(prod_main[i]) + SW'(prod_pos[i]) - SW'(prod_neg[i]) + Half;
      shift_vec[i] = sum_vec[i] >>> F;
    end

    always_ff @(posedge clk) begin
      if (ctl.load_b) begin
        t_vec[i] <= shift_vec[i][TW-1:0];
      end
    end
  end

  always_comb begin
    sum_dot   = SW'(prod_dot[0]) + SW'(prod_dot[1]) + SW'(prod_dot[2]) + Half;
    shift_dot = sum_dot >>> F;
  end

  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      quat_a <= quat;
    end
    if (ctl.load_b) begin
      t_w    <= shift_dot[TW-1:0];
      quat_d <= quat_a;
    end
  end

endmodule

FILE: src/qvr_rot_mul.sv
module qvr_rot_mul #(
  parameter int COMP_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  qvr_pkg::pair_ctl_t              ctl,
  input  logic signed [COMP_WIDTH-1:0]    quat [4],
  input  logic signed [COMP_WIDTH+3:0]    t_vec [3],
  input  logic signed [COMP_WIDTH+3:0]    t_w,
  output qvr_pkg::pair_vld_t              vld,
  output logic signed [COMP_WIDTH-1:0]    rot [3],
  output logic                            clipped
);
  import qvr_pkg::*;

  localparam int F  = COMP_WIDTH - 1;
  localparam int PW = 2 * COMP_WIDTH + 4;
  localparam int SW = 2 * COMP_WIDTH + 6;
  localparam logic signed [SW-1:0] Half  = SW'(64'd1 << (F - 1));
  localparam logic signed [SW-1:0] SatHi = SW'((64'sd1 <<< (COMP_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SatLo = ~SatHi;

  logic signed [PW-1:0]         prod_main [3];
  logic signed [PW-1:0]         prod_scal [3];
  logic signed [PW-1:0]         prod_pos [3];
  logic signed [PW-1:0]         prod_neg [3];
  logic signed [SW-1:0]         sum_vec [3];
  logic signed [SW-1:0]         shift_vec [3];
  logic signed [COMP_WIDTH-1:0] rot_next [3];
  logic [2:0]                   sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld.a <= 1'b0;
      vld.b <= 1'b0;
    end else begin
      if (ctl.load_a) begin
        vld.a <= in_valid;
      end
      if (ctl.load_b) begin
        vld.b <= vld.a;
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_comp
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    always_ff @(posedge clk) begin
      if (ctl.load_a) begin
        prod_main[i] <= quat[3] * t_vec[i];
        prod_scal[i] <= t_w * quat[i];
        prod_pos[i]  <= quat[J] * t_vec[K];
        prod_neg[i]  <= quat[K] * t_vec[J];
      end
    end

    always_comb begin
      sum_vec[i] = SW'(prod_main[i]) + SW'(prod_scal[i]) + SW'(prod_pos[i])
                 - SW'(prod_neg[i]) + Half;
      shift_vec[i] = sum_vec[i] >>> F;
      sat[i] = 1'b1;
      if (shift_vec[i] > SatHi) begin
        rot_next[i] = SatHi[COMP_WIDTH-1:0];
      end else if (shift_vec[i] < SatLo) begin
        rot_next[i] = SatLo[COMP_WIDTH-1:0];
      end else begin
        rot_next[i] = shift_vec[i][COMP_WIDTH-1:0];
        sat[i]      = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.load_b) begin
        rot[i] <= rot_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_b) begin
      clipped <= |sat;
    end
  end

endmodule

FILE: src/qvr_check.sv
module qvr_check #(
  parameter int COMP_WIDTH = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         vec_valid,
  input logic                         vec_stall,
  input logic signed [COMP_WIDTH-1:0] quat_x,
  input logic signed [COMP_WIDTH-1:0] quat_y,
  input logic signed [COMP_WIDTH-1:0] quat_z,
  input logic signed [COMP_WIDTH-1:0] quat_w,
  input logic signed [COMP_WIDTH-1:0] vec_x,
  input logic signed [COMP_WIDTH-1:0] vec_y,
  input logic signed [COMP_WIDTH-1:0] vec_z,
  input logic                         rot_valid,
  input logic                         rot_stall,
  input logic signed [COMP_WIDTH-1:0] rot_x,
  input logic signed [COMP_WIDTH-1:0] rot_y,
  input logic signed [COMP_WIDTH-1:0] rot_z,
  input logic                         clipped
);

  localparam logic signed [COMP_WIDTH-1:0] SatHi = {1'b0, {(COMP_WIDTH - 1){1'b1}}};
  localparam logic signed [COMP_WIDTH-1:0] SatLo = {1'b1, {(COMP_WIDTH - 1){1'b0}}};

  logic quat_seen;
  logic vec_seen;

  assign quat_seen = ^{quat_x, quat_y, quat_z, quat_w};
  assign vec_seen  = ^{vec_x, vec_y, vec_z, vec_valid};

  a_rot_held: assert property (@(posedge clk) disable iff (rst)
    rot_valid && rot_stall |=> rot_valid)
    else $error("result transaction dropped while stalled");

  a_rot_stable: assert property (@(posedge clk) disable iff (rst)
    rot_valid && rot_stall |=> $stable(rot_x) && $stable(rot_y) && $stable(rot_z)
      && $stable(clipped))
    else $error("stalled result changed");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !rot_valid |-> !vec_stall)
    else $error("input stalled with no result waiting");

  a_clip_at_bound: assert property (@(posedge clk) disable iff (rst)
    rot_valid && clipped |-> rot_x == SatHi || rot_x == SatLo || rot_y == SatHi
      || rot_y == SatLo || rot_z == SatHi || rot_z == SatLo)
    else $error("clipped set with no component at a bound");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst && (quat_seen || !quat_seen) && (vec_seen || !vec_seen)
      |-> !rot_valid)
    else $error("result valid straight after reset");

endmodule

bind quaternion_vector_rotate qvr_check #(.COMP_WIDTH(COMP_WIDTH)) u_qvr_check (.*);
